// File: rtl/core/sle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_pkg
// Shared constants, codes and types of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY    = 256;
	localparam int ENTRY_WIDTH = 32;

	localparam int CMD_W  = 3;
	localparam int POS_W  = 9;
	localparam int VAL_W  = 32;
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int WIDE_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int GROUP   = 16;
	localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_END   = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_REM_FRONT = 3'd3,
		CMD_REM_END   = 3'd4,
		CMD_REM_AT    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CNT_W-1:0]       pos;
		logic [ENTRY_WIDTH-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic             valid;
		logic             rem_ok;
		status_t          status;
		logic [CNT_W-1:0] count;
	} stage_t;

endpackage
`default_nettype wire

// File: rtl/core/sle_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: on insert it takes its left neighbor past the target slot
// or the new entry at it; on remove it takes its right neighbor from it on.
// ----------------------------------------------------------------------------
module sle_cell (
	input  wire logic                           clk,
	input  wire logic [sle_pkg::CNT_W-1:0]       idx,
	input  wire sle_pkg::cell_ctl_t              ctl,
	input  wire logic [sle_pkg::ENTRY_WIDTH-1:0] left_d,
	input  wire logic [sle_pkg::ENTRY_WIDTH-1:0] right_d,
	output logic      [sle_pkg::ENTRY_WIDTH-1:0] entry_q,
	output logic                                sel
);

	assign sel = (idx == ctl.pos);

	always_ff @(posedge clk) begin
		case (ctl.op)
			sle_pkg::CELL_INS: begin
				if (idx > ctl.pos) begin
					entry_q <= left_d;
				end else if (idx == ctl.pos) begin
					entry_q <= ctl.value;
				end
			end
			sle_pkg::CELL_REM: begin
				if (idx >= ctl.pos) begin
					entry_q <= right_d;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/sle_gather.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_gather
// Two-level registered OR tree that picks the target slot's entry before
// the shift: groups of cells are reduced into registers, then combined.
// ----------------------------------------------------------------------------
module sle_gather (
	input  wire logic                           clk,
	input  wire logic                           capture,
	input  wire logic [sle_pkg::ENTRY_WIDTH-1:0] cell_d [sle_pkg::CAPACITY],
	input  wire logic [sle_pkg::CAPACITY-1:0]    sel,
	output logic      [sle_pkg::ENTRY_WIDTH-1:0] picked
);

	logic [sle_pkg::ENTRY_WIDTH-1:0] term   [sle_pkg::NGROUPS][sle_pkg::GROUP];
	logic [sle_pkg::ENTRY_WIDTH-1:0] grp_d  [sle_pkg::NGROUPS];
	logic [sle_pkg::ENTRY_WIDTH-1:0] group_q[sle_pkg::NGROUPS];

	for (genvar g = 0; g < sle_pkg::NGROUPS; g++) begin : g_grp
		for (genvar k = 0; k < sle_pkg::GROUP; k++) begin : g_term
			localparam int I = g * sle_pkg::GROUP + k;
			if (I < sle_pkg::CAPACITY) begin : g_live
				assign term[g][k] = sel[I] ? cell_d[I] : '0;
			end else begin : g_pad
				assign term[g][k] = '0;
			end
		end

		always_comb begin
			grp_d[g] = '0;
			for (int k = 0; k < sle_pkg::GROUP; k++) begin
				grp_d[g] = grp_d[g] | term[g][k];
			end
		end

		always_ff @(posedge clk) begin
			if (capture) begin
				group_q[g] <= grp_d[g];
			end
		end
	end

	always_comb begin
		picked = '0;
		for (int g = 0; g < sle_pkg::NGROUPS; g++) begin
			picked = picked | group_q[g];
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sle_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sle_ctrl
// Command decode, bounds checks and entry count; drives the cell row.
// ----------------------------------------------------------------------------
module sle_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [sle_pkg::CMD_W-1:0] command,
	input  wire logic [sle_pkg::POS_W-1:0] position,
	input  wire logic [sle_pkg::VAL_W-1:0] entry_value,
	output logic                           busy,
	output sle_pkg::cell_ctl_t             ctl,
	output sle_pkg::stage_t                stage_s1
);

	logic [sle_pkg::CNT_W-1:0]  count_q;
	logic [sle_pkg::CNT_W-1:0]  new_count;
	logic [sle_pkg::CNT_W-1:0]  pos_d;
	logic [sle_pkg::WIDE_W-1:0] pos_w;
	logic [sle_pkg::WIDE_W-1:0] cnt_w;
	logic [2*sle_pkg::VAL_W-1:0] val_ext;
	sle_pkg::cell_op_t          op_d;
	sle_pkg::status_t           st_d;
	logic                       accept;
	logic                       full;
	logic                       empty;

	assign busy    = stage_s1.valid;
	assign accept  = start && !busy;
	assign pos_w   = sle_pkg::WIDE_W'(position);
	assign cnt_w   = sle_pkg::WIDE_W'(count_q);
	assign full    = (count_q == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
	assign empty   = (count_q == '0);
	assign val_ext = (2*sle_pkg::VAL_W)'(entry_value);

	always_comb begin
		op_d      = sle_pkg::CELL_HOLD;
		st_d      = sle_pkg::ST_OK;
		pos_d     = '0;
		case (sle_pkg::cmd_t'(command))
			sle_pkg::CMD_INS_FRONT: begin
				if (full) st_d = sle_pkg::ST_FULL;
				else op_d = sle_pkg::CELL_INS;
			end
			sle_pkg::CMD_INS_END: begin
				if (full) st_d = sle_pkg::ST_FULL;
				else begin
					op_d  = sle_pkg::CELL_INS;
					pos_d = count_q;
				end
			end
			sle_pkg::CMD_INS_AT: begin
				if (full) st_d = sle_pkg::ST_FULL;
				else if (pos_w > cnt_w) st_d = sle_pkg::ST_RANGE;
				else begin
					op_d  = sle_pkg::CELL_INS;
					pos_d = pos_w[sle_pkg::CNT_W-1:0];
				end
			end
			sle_pkg::CMD_REM_FRONT: begin
				if (empty) st_d = sle_pkg::ST_EMPTY;
				else op_d = sle_pkg::CELL_REM;
			end
			sle_pkg::CMD_REM_END: begin
				if (empty) st_d = sle_pkg::ST_EMPTY;
				else begin
					op_d  = sle_pkg::CELL_REM;
					pos_d = count_q - sle_pkg::CNT_W'(1);
				end
			end
			sle_pkg::CMD_REM_AT: begin
				if (empty) st_d = sle_pkg::ST_EMPTY;
				else if (pos_w >= cnt_w) st_d = sle_pkg::ST_RANGE;
				else begin
					op_d  = sle_pkg::CELL_REM;
					pos_d = pos_w[sle_pkg::CNT_W-1:0];
				end
			end
			default: begin
				st_d = sle_pkg::ST_RANGE;
			end
		endcase
	end

	always_comb begin
		case (op_d)
			sle_pkg::CELL_INS: new_count = count_q + sle_pkg::CNT_W'(1);
			sle_pkg::CELL_REM: new_count = count_q - sle_pkg::CNT_W'(1);
			default:           new_count = count_q;
		endcase
	end

	assign ctl.op    = accept ? op_d : sle_pkg::CELL_HOLD;
	assign ctl.pos   = pos_d;
	assign ctl.value = val_ext[sle_pkg::ENTRY_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			stage_s1 <= '0;
		end else if (accept) begin
			count_q         <= new_count;
			stage_s1.valid  <= 1'b1;
			stage_s1.rem_ok <= (op_d == sle_pkg::CELL_REM);
			stage_s1.status <= st_d;
			stage_s1.count  <= new_count;
		end else begin
			stage_s1.valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sequential_list_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_list_engine
// Bounded ordered list held in a row of shifting cells; inserts and removes
// at front, end or a given position, one request at a time.
// ----------------------------------------------------------------------------
// channel   handshake        payload
// request   start / busy     command, position, entry_value
// result    done (strobe)    removed_value, status, entry_count
//
// On accept, the whole cell row shifts at once and, on a removal, the group
// registers of the removal OR tree latch the target entry; the groups are
// then combined into the result registers. busy is high for the
// one cycle in between. Reset clears the count and control; cell contents
// are not cleared. The result cannot be stalled.
// ----------------------------------------------------------------------------
module sequential_list_engine (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [sle_pkg::CMD_W-1:0] command,
	input  wire logic [sle_pkg::POS_W-1:0] position,
	input  wire logic [sle_pkg::VAL_W-1:0] entry_value,
	output logic                           done,
	output logic [sle_pkg::VAL_W-1:0]      removed_value,
	output logic [1:0]                     status,
	output logic [sle_pkg::POS_W-1:0]      entry_count
);

	sle_pkg::cell_ctl_t              ctl;
	sle_pkg::stage_t                 stage_s1;
	logic [sle_pkg::ENTRY_WIDTH-1:0] cell_q [sle_pkg::CAPACITY];
	logic [sle_pkg::CAPACITY-1:0]    sel;
	logic [sle_pkg::ENTRY_WIDTH-1:0] picked;
	logic [2*sle_pkg::VAL_W-1:0]     rem_ext;
	logic [sle_pkg::WIDE_W-1:0]      cnt_ext;
	logic                            done_q;
	logic [sle_pkg::VAL_W-1:0]       removed_q;
	logic [1:0]                      status_q;
	logic [sle_pkg::POS_W-1:0]       count_out_q;

	sle_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.position    (position),
		.entry_value (entry_value),
		.busy        (busy),
		.ctl         (ctl),
		.stage_s1    (stage_s1)
	);

	for (genvar i = 0; i < sle_pkg::CAPACITY; i++) begin : g_cell
		logic [sle_pkg::ENTRY_WIDTH-1:0] left_d;
		logic [sle_pkg::ENTRY_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_q[i-1];
		end

		if (i == sle_pkg::CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_q[i+1];
		end

		sle_cell u_cell (
			.clk     (clk),
			.idx     (sle_pkg::CNT_W'(i)),
			.ctl     (ctl),
			.left_d  (left_d),
			.right_d (right_d),
			.entry_q (cell_q[i]),
			.sel     (sel[i])
		);
	end

	sle_gather u_gather (
		.clk     (clk),
		.capture (ctl.op == sle_pkg::CELL_REM),
		.cell_d  (cell_q),
		.sel     (sel),
		.picked  (picked)
	);

	assign rem_ext = (2*sle_pkg::VAL_W)'(picked);
	assign cnt_ext = sle_pkg::WIDE_W'(stage_s1.count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_s1.valid) begin
			removed_q   <= stage_s1.rem_ok ? rem_ext[sle_pkg::VAL_W-1:0] : '0;
			status_q    <= stage_s1.status;
			count_out_q <= cnt_ext[sle_pkg::POS_W-1:0];
		end
	end

	assign done          = done_q;
	assign removed_value = removed_q;
	assign status        = status_q;
	assign entry_count   = count_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("busy cycle not followed by result strobe");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("busy and done high together");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != sle_pkg::ST_OK)) |-> (removed_value == '0))
		else $error("failed request returned a removed entry");

endmodule
`default_nettype wire
